/* src/input_frame_record_replay_core_assert.svh */
// Assertion macros for the frame record/replay core.
// Used by files that include this header; depends on clk and arst_n being in scope.
`ifndef INPUT_FRAME_RECORD_REPLAY_CORE_ASSERT_SVH
`define INPUT_FRAME_RECORD_REPLAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define IFRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define IFRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IFRR_ASSERT(lbl, prop, msg)
`define IFRR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/ifrr_pkg.sv */
// Shared types and constants of the frame record/replay core.
// No dependencies; imported by the frame RAM and the top level.
`default_nettype none

package ifrr_pkg;

	// Frame store size and derived widths
	localparam int unsigned FRAME_DEPTH = 4096;
	localparam int unsigned ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int unsigned POS_W       = $clog2(FRAME_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_RECORDING = 2'd2,
		MODE_PLAYING   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		FUNC_TICK       = 3'd0,
		FUNC_REC_START  = 3'd1,
		FUNC_REC_STOP   = 3'd2,
		FUNC_PLAY_START = 3'd3,
		FUNC_PLAY_STOP  = 3'd4,
		FUNC_REWIND     = 3'd5,
		FUNC_TRIM       = 3'd6,
		FUNC_NOP        = 3'd7
	} func_t;

	// Command channel payload
	typedef struct packed {
		logic [2:0]        func;
		logic [15:0]       pad_buttons;
		logic signed [7:0] pad_stick_x;
		logic signed [7:0] pad_stick_y;
	} cmd_t;

	// Result channel payload
	typedef struct packed {
		logic [1:0]        mode_now;
		logic              inject_valid;
		logic [15:0]       play_buttons;
		logic signed [7:0] play_stick_x;
		logic signed [7:0] play_stick_y;
		logic [15:0]       play_pressed;
		logic              hold_game;
		logic [POS_W-1:0]  head_now;
		logic [POS_W-1:0]  length_now;
		logic              full_now;
	} res_t;

	// One stored frame: y in 31..24, x in 23..16, buttons in 15..0
	typedef struct packed {
		logic [7:0]  stick_y;
		logic [7:0]  stick_x;
		logic [15:0] buttons;
	} frame_t;

	// Frame RAM access request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		frame_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

/* src/input_frame_record_replay_core.sv */
// Top level of the controller frame record/replay core.
// Depends on ifrr_pkg, ifrr_frame_ram and the assertion macro header.
//
//  channel | signals                       | direction | moves
//  cmd     | cmd_valid, cmd_stall, cmd     | in        | one command or tick per transfer
//  res     | res_valid, res_stall, res     | out       | one result per accepted command
//  cfg     | cfg_wr_en, cfg_wr_data        | in        | loop enable register write
//
// One command per cycle while cmd_stall is low; its result is registered in stage 1
// and then in the output register before res_valid rises.
// Control state updates at the transfer; the frame RAM read issued then is
// merged with the pressed-edge tracking in the second stage.
// Reset is asynchronous; the frame store is not cleared and needs no pass.
// A stalled result holds the second stage, and cmd_stall rises only when
// both stages are full.
`default_nettype none
`include "input_frame_record_replay_core_assert.svh"

module input_frame_record_replay_core
	import ifrr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data
);

	localparam logic [POS_W-1:0] CAP = POS_W'(FRAME_DEPTH);
	localparam logic [POS_W-1:0] ONE = POS_W'(1);

	// Control state
	mode_t            mode_q, mode_d;
	logic [POS_W-1:0] head_q, head_d;
	logic [POS_W-1:0] len_q, len_d;
	logic             full_q, full_d;
	logic             loop_q;
	logic [15:0]      prev_q;

	// Stage 1
	logic             s1_valid_s1;
	mode_t            mode_s1;
	logic             inj_s1;
	logic             clr_prev_s1;
	logic [POS_W-1:0] head_s1;
	logic [POS_W-1:0] len_s1;
	logic             full_s1;

	// Output register
	logic res_valid_q;
	res_t res_q;

	logic     accept;
	logic     res_adv;
	logic     pad_nz;
	logic     at_cap;
	logic     cap_en;
	logic     rd_en;
	logic     inj_d;
	logic     clr_prev_d;
	ram_req_t ram_req;
	frame_t   rd_frame;
	frame_t   pad_frame;
	res_t     res_d;

	// Handshake
	assign res_adv   = s1_valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = s1_valid_s1 && !res_adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Loop enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
		end else if (cfg_wr_en) begin
			loop_q <= cfg_wr_data;
		end
	end

	assign pad_frame = '{stick_y: cmd.pad_stick_y, stick_x: cmd.pad_stick_x,
		buttons: cmd.pad_buttons};
	assign pad_nz = |pad_frame;
	assign at_cap = head_q >= CAP;

	// Next state of the mode machine and counters
	always_comb begin
		mode_d     = mode_q;
		head_d     = head_q;
		len_d      = len_q;
		full_d     = full_q;
		cap_en     = 1'b0;
		rd_en      = 1'b0;
		inj_d      = 1'b0;
		clr_prev_d = 1'b0;
		unique case (func_t'(cmd.func))
			FUNC_TICK: begin
				unique case (mode_q)
					MODE_ARMED: begin
						if (pad_nz) begin
							if (at_cap) begin
								mode_d = MODE_IDLE;
								full_d = 1'b1;
							end else begin
								mode_d = MODE_RECORDING;
								cap_en = 1'b1;
							end
						end
					end
					MODE_RECORDING: begin
						if (!at_cap) begin
							cap_en = 1'b1;
						end else begin
							mode_d = MODE_IDLE;
							full_d = 1'b1;
						end
					end
					MODE_PLAYING: begin
						if (head_q < len_q) begin
							rd_en  = 1'b1;
							inj_d  = 1'b1;
							head_d = head_q + ONE;
						end else begin
							if (loop_q) begin
								head_d = '0;
							end else begin
								mode_d = MODE_IDLE;
							end
							clr_prev_d = 1'b1;
						end
					end
					MODE_IDLE: begin
					end
					default: begin
					end
				endcase
				// Capture one frame at the head
				if (cap_en) begin
					head_d = head_q + ONE;
					len_d  = head_q + ONE;
				end
			end
			FUNC_REC_START: begin
				// Append when parked at the trim point
				if (!(head_q == len_q && len_q != '0)) begin
					head_d = '0;
					len_d  = '0;
				end
				mode_d     = MODE_ARMED;
				clr_prev_d = 1'b1;
				full_d     = 1'b0;
			end
			FUNC_REC_STOP: begin
				if (mode_q == MODE_ARMED || mode_q == MODE_RECORDING) begin
					mode_d = MODE_IDLE;
				end
			end
			FUNC_PLAY_START: begin
				if (len_q != '0) begin
					mode_d     = MODE_PLAYING;
					head_d     = '0;
					clr_prev_d = 1'b1;
				end
			end
			FUNC_PLAY_STOP: begin
				if (mode_q == MODE_PLAYING) begin
					mode_d     = MODE_IDLE;
					clr_prev_d = 1'b1;
				end
			end
			FUNC_REWIND: begin
				head_d     = '0;
				clr_prev_d = 1'b1;
			end
			FUNC_TRIM: begin
				if (len_q != '0 && head_q <= len_q) begin
					len_d = head_q;
					if (head_q == '0) begin
						full_d = 1'b0;
					end
				end
			end
			FUNC_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Control state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			head_q <= '0;
			len_q  <= '0;
			full_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			head_q <= head_d;
			len_q  <= len_d;
			full_q <= full_d;
		end
	end

	// Frame store access
	always_comb begin
		ram_req.we    = accept && cap_en;
		ram_req.waddr = head_q[ADDR_W-1:0];
		ram_req.wdata = pad_frame;
		ram_req.re    = accept && rd_en;
		ram_req.raddr = head_q[ADDR_W-1:0];
	end

	ifrr_frame_ram u_frame_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rd_frame)
	);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (res_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode_d;
			inj_s1      <= inj_d;
			clr_prev_s1 <= clr_prev_d;
			head_s1     <= head_d;
			len_s1      <= len_d;
			full_s1     <= full_d;
		end
	end

	// Previous played buttons, advanced in command order at stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (res_adv) begin
			if (inj_s1) begin
				prev_q <= rd_frame.buttons;
			end else if (clr_prev_s1) begin
				prev_q <= '0;
			end
		end
	end

	// Result assembly
	always_comb begin
		res_d.mode_now     = mode_s1;
		res_d.inject_valid = inj_s1;
		res_d.play_buttons = inj_s1 ? rd_frame.buttons : 16'd0;
		res_d.play_stick_x = inj_s1 ? rd_frame.stick_x : 8'd0;
		res_d.play_stick_y = inj_s1 ? rd_frame.stick_y : 8'd0;
		res_d.play_pressed = inj_s1 ? (rd_frame.buttons & ~prev_q) : 16'd0;
		res_d.hold_game    = (mode_s1 == MODE_ARMED);
		res_d.head_now     = head_s1;
		res_d.length_now   = len_s1;
		res_d.full_now     = full_s1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_adv) begin
			res_q <= res_d;
		end
	end

	// Checks
	`IFRR_ASSERT(a_head_range, head_q <= CAP, "head position beyond store depth")
	`IFRR_ASSERT(a_len_range, len_q <= CAP, "recorded length beyond store depth")
	`IFRR_ASSERT(a_inject_mode,
		!(res_valid_q && res_q.inject_valid) || res_q.mode_now == MODE_PLAYING,
		"frame injected outside playback")
	`IFRR_ASSERT(a_quiet_fields,
		!(res_valid_q && !res_q.inject_valid) ||
		(res_q.play_buttons == 16'd0 && res_q.play_pressed == 16'd0),
		"played fields set without inject")
	`IFRR_ASSERT_NEXT(a_rd_hold, s1_valid_s1 && inj_s1 && !res_adv, $stable(rd_frame),
		"read data changed under a held stage")

endmodule

`default_nettype wire

/* src/ifrr_frame_ram.sv */
// Frame store: one write port, one registered read port.
// Depends on ifrr_pkg for depth, address width and the request type.
`default_nettype none

module ifrr_frame_ram
	import ifrr_pkg::*;
(
	input  wire logic     clk,
	input  wire ram_req_t req,
	output frame_t        rdata
);

	frame_t mem [FRAME_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire
